// File: src/dpce_pkg.sv
// Shared types, constants and CRC helpers for the delta packet CRC encoder.
// No dependencies.
package dpce_pkg;

	localparam int NumReadings = 6;
	localparam int NumDeltas   = NumReadings + 1;
	localparam int NumWords    = NumDeltas + 1;
	localparam int QueueDepth  = 2;

	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcTop  = 16'h8000;

	typedef logic [15:0] word_t;

	// One delta record: sequence plus time delta and six reading deltas.
	typedef struct packed {
		word_t                 seq;
		word_t [NumDeltas-1:0] delta;
	} rec_t;

	// MSB-first CRC-16 over one byte.
	function automatic word_t crc_byte(word_t crc, logic [7:0] b);
		word_t c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CrcTop) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Fold one 16-bit word, low byte first.
	function automatic word_t crc_word(word_t crc, word_t w);
		word_t c;
		c = crc_byte(crc, w[7:0]);
		c = crc_byte(c, w[15:8]);
		return c;
	endfunction

endpackage

// File: src/dpce_front.sv
// Front end: accepts sensor words, forms wrapped deltas against history.
// Depends on dpce_pkg.
module dpce_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic        [15:0] seq_number,
	input  logic        [15:0] time_ms_low,
	input  logic signed [15:0] temp_reading,
	input  logic signed [15:0] depth_reading,
	input  logic signed [15:0] salinity_reading,
	input  logic signed [15:0] oxygen_reading,
	input  logic signed [15:0] chlorophyll_reading,
	input  logic signed [15:0] acidity_reading,
	input  logic               q_full,
	output logic               push,
	output dpce_pkg::rec_t     push_rec
);
	import dpce_pkg::*;

	word_t last_time_q;
	word_t last_rd_q [NumReadings];
	word_t cur_rd    [NumReadings];

	assign push = in_valid && !q_full;

	always_comb begin
		cur_rd[0] = word_t'(temp_reading);
		cur_rd[1] = word_t'(depth_reading);
		cur_rd[2] = word_t'(salinity_reading);
		cur_rd[3] = word_t'(oxygen_reading);
		cur_rd[4] = word_t'(chlorophyll_reading);
		cur_rd[5] = word_t'(acidity_reading);
	end

	always_comb begin
		push_rec.seq      = seq_number;
		push_rec.delta[0] = time_ms_low - last_time_q;
		for (int i = 0; i < NumReadings; i++) begin
			push_rec.delta[i+1] = cur_rd[i] - last_rd_q[i];
		end
	end

	// history starts at zero, so the first word's deltas are the raw values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			for (int i = 0; i < NumReadings; i++) begin
				last_rd_q[i] <= '0;
			end
		end else if (push) begin
			last_time_q <= time_ms_low;
			for (int i = 0; i < NumReadings; i++) begin
				last_rd_q[i] <= cur_rd[i];
			end
		end
	end

endmodule

// File: src/dpce_queue.sv
// Short FIFO decoupling the delta front end from the CRC back end.
// Depends on dpce_pkg.
module dpce_queue #(
	parameter int Depth = dpce_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dpce_pkg::rec_t push_rec,
	input  logic           pop,
	output logic           q_full,
	output logic           q_valid,
	output dpce_pkg::rec_t q_rec
);
	import dpce_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	rec_t            entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
		logic [PtrW-1:0] n;
		if (p == PtrW'(Depth - 1)) begin
			n = '0;
		end else begin
			n = p + PtrW'(1);
		end
		return n;
	endfunction

	assign q_full  = (count_q == CntW'(Depth));
	assign q_valid = (count_q != '0);
	assign q_rec   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count over depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");
	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count failed to rise");
	a_count_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - CntW'(1)))
		else $error("queue count failed to fall");
`endif

endmodule

// File: src/dpce_back.sv
// Back end: stallable CRC pipeline, one 16-bit word folded per stage.
// Depends on dpce_pkg.
module dpce_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  dpce_pkg::rec_t q_rec,
	output logic           pop,
	input  logic           out_stall,
	output logic           out_valid,
	output dpce_pkg::rec_t out_rec,
	output logic    [15:0] out_crc
);
	import dpce_pkg::*;

	logic [NumWords-1:0] vld_s;
	rec_t                rec_s [NumWords];
	word_t               crc_s [NumWords];

	logic [NumWords:0]   adv;
	logic [NumWords-1:0] v_in;
	rec_t                r_in  [NumWords];
	word_t               c_in  [NumWords];
	word_t               w_in  [NumWords];

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		adv[NumWords] = !out_stall;
		for (int i = NumWords - 1; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign pop = q_valid && adv[0];

	for (genvar g = 0; g < NumWords; g++) begin : g_stage
		if (g == 0) begin : g_head
			assign v_in[g] = q_valid;
			assign r_in[g] = q_rec;
			assign c_in[g] = CrcInit;
			assign w_in[g] = q_rec.seq;
		end else begin : g_body
			assign v_in[g] = vld_s[g-1];
			assign r_in[g] = rec_s[g-1];
			assign c_in[g] = crc_s[g-1];
			assign w_in[g] = rec_s[g-1].delta[g-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv[g]) begin
				vld_s[g] <= v_in[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[g] && v_in[g]) begin
				rec_s[g] <= r_in[g];
				crc_s[g] <= crc_word(c_in[g], w_in[g]);
			end
		end
	end

	assign out_valid = vld_s[NumWords-1];
	assign out_rec   = rec_s[NumWords-1];
	assign out_crc   = crc_s[NumWords-1];

endmodule

// File: src/delta_packet_crc_encoder_core.sv
// Top level of the delta packet CRC encoder: front end, queue, CRC back end.
// Depends on dpce_pkg, dpce_front, dpce_queue, dpce_back.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   input   | in_valid / in_stall   | seq_number, time_ms_low, six readings
//   output  | out_valid / out_stall | seq_echo, packet_check, seven changes
//
// One word per cycle sustained while out_stall is low; set by the queue's push/pop
// and the CRC pipeline, which folds one 16-bit word per stage over eight stages.
// Unstalled, the first stage loads on the edge after the queue write, and the
// record then steps through the stages in order to the last, which drives out_valid.
// Reset clears the delta history to zero and all valid state; no sweep.
// out_stall freezes the CRC pipeline from the tail; bubbles still close up.
// in_stall rises only when the queue is full, from a register.
module delta_packet_crc_encoder_core #(
	parameter int QueueDepth = dpce_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic        [15:0] seq_number,
	input  logic        [15:0] time_ms_low,
	input  logic signed [15:0] temp_reading,
	input  logic signed [15:0] depth_reading,
	input  logic signed [15:0] salinity_reading,
	input  logic signed [15:0] oxygen_reading,
	input  logic signed [15:0] chlorophyll_reading,
	input  logic signed [15:0] acidity_reading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic        [15:0] seq_echo,
	output logic        [15:0] packet_check,
	output logic signed [15:0] time_change,
	output logic signed [15:0] temp_change,
	output logic signed [15:0] depth_change,
	output logic signed [15:0] salinity_change,
	output logic signed [15:0] oxygen_change,
	output logic signed [15:0] chlorophyll_change,
	output logic signed [15:0] acidity_change
);
	import dpce_pkg::*;

	// front to queue
	logic  push;
	rec_t  push_rec;
	logic  q_full;

	// queue to back
	logic  q_valid;
	rec_t  q_rec;
	logic  pop;

	// back to ports
	rec_t  out_rec;
	word_t out_crc;

	assign in_stall = q_full;

	dpce_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.seq_number          (seq_number),
		.time_ms_low         (time_ms_low),
		.temp_reading        (temp_reading),
		.depth_reading       (depth_reading),
		.salinity_reading    (salinity_reading),
		.oxygen_reading      (oxygen_reading),
		.chlorophyll_reading (chlorophyll_reading),
		.acidity_reading     (acidity_reading),
		.q_full              (q_full),
		.push                (push),
		.push_rec            (push_rec)
	);

	dpce_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.q_full   (q_full),
		.q_valid  (q_valid),
		.q_rec    (q_rec)
	);

	dpce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_rec     (q_rec),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_rec   (out_rec),
		.out_crc   (out_crc)
	);

	// delta slot 0 is time, then the readings in port order
	assign seq_echo           = out_rec.seq;
	assign packet_check       = out_crc;
	assign time_change        = signed'(out_rec.delta[0]);
	assign temp_change        = signed'(out_rec.delta[1]);
	assign depth_change       = signed'(out_rec.delta[2]);
	assign salinity_change    = signed'(out_rec.delta[3]);
	assign oxygen_change      = signed'(out_rec.delta[4]);
	assign chlorophyll_change = signed'(out_rec.delta[5]);
	assign acidity_change     = signed'(out_rec.delta[6]);

endmodule

// File: bench/delta_packet_crc_encoder_checker.sv
`timescale 1ns / 1ps
// Checker for the delta packet CRC encoder: predicts each output word from the inputs.
// Depends on dpce_pkg (word type, sizes, CRC constants).
module delta_packet_crc_encoder_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] seq_number,
	input  logic [15:0] time_ms_low,
	input  logic [15:0] temp_reading,
	input  logic [15:0] depth_reading,
	input  logic [15:0] salinity_reading,
	input  logic [15:0] oxygen_reading,
	input  logic [15:0] chlorophyll_reading,
	input  logic [15:0] acidity_reading,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] seq_echo,
	input  logic [15:0] packet_check,
	input  logic [15:0] time_change,
	input  logic [15:0] temp_change,
	input  logic [15:0] depth_change,
	input  logic [15:0] salinity_change,
	input  logic [15:0] oxygen_change,
	input  logic [15:0] chlorophyll_change,
	input  logic [15:0] acidity_change,
	output int          fail_count,
	output int          pending_count
);
	import dpce_pkg::*;

	// change[0] is the time delta, change[1..6] the reading deltas
	typedef struct packed {
		word_t                 seq;
		word_t                 check;
		word_t [NumDeltas-1:0] change;
	} packet_t;

	packet_t                 expected_packets[$];
	word_t                   prev_stamp;
	word_t [NumReadings-1:0] prev_reading;
	word_t [NumReadings-1:0] now_reading;
	packet_t                 want;
	packet_t                 got;

	string change_name [NumDeltas] = '{"time_change", "temp_change", "depth_change",
		"salinity_change", "oxygen_change", "chlorophyll_change", "acidity_change"};

	// CCITT-FALSE fold of one word, low byte first, bit-serial MSB first
	function automatic word_t crc_fold(word_t crc, word_t w);
		word_t      c;
		logic [7:0] octet;
		logic       fb;
		c = crc;
		for (int k = 0; k < 2; k++) begin
			octet = w[8*k +: 8];
			for (int i = 7; i >= 0; i--) begin
				fb = c[15] ^ octet[i];
				c  = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ CrcPoly;
				end
			end
		end
		return c;
	endfunction

	task automatic report(string msg);
		$display("[%0t] MISMATCH %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_stamp   = '0;
			prev_reading = '0;
			expected_packets.delete();
			pending_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.seq    = seq_echo;
				got.check  = packet_check;
				got.change = {acidity_change, chlorophyll_change, oxygen_change,
					salinity_change, depth_change, temp_change, time_change};
				if (expected_packets.size() == 0) begin
					report($sformatf("output word seq=%04h with nothing expected", got.seq));
				end else begin
					want = expected_packets.pop_front();
					if (got.seq !== want.seq)
						report($sformatf("seq_echo got %04h want %04h", got.seq, want.seq));
					if (got.check !== want.check)
						report($sformatf("packet_check got %04h want %04h (seq %04h)",
							got.check, want.check, want.seq));
					for (int d = 0; d < NumDeltas; d++) begin
						if (got.change[d] !== want.change[d])
							report($sformatf("%s got %04h want %04h (seq %04h)",
								change_name[d], got.change[d], want.change[d], want.seq));
					end
				end
			end
			if (in_valid && !in_stall) begin
				now_reading = {acidity_reading, chlorophyll_reading, oxygen_reading,
					salinity_reading, depth_reading, temp_reading};
				want.seq       = seq_number;
				want.change[0] = time_ms_low - prev_stamp;
				for (int r = 0; r < NumReadings; r++)
					want.change[r+1] = now_reading[r] - prev_reading[r];
				want.check = crc_fold(CrcInit, seq_number);
				for (int d = 0; d < NumDeltas; d++)
					want.check = crc_fold(want.check, want.change[d]);
				prev_stamp   = time_ms_low;
				prev_reading = now_reading;
				expected_packets.push_back(want);
			end
			pending_count = expected_packets.size();
		end
	end

endmodule

// File: bench/delta_packet_crc_encoder_core_test.sv
`timescale 1ns / 1ps
// Top of the delta packet CRC encoder bench: clock, reset, stimulus, verdict.
// Depends on dpce_pkg, delta_packet_crc_encoder_core, delta_packet_crc_encoder_checker.
module delta_packet_crc_encoder_core_test;
	import dpce_pkg::*;

	localparam int RandomRecords = 1250;
	localparam int CalmTail      = 150;   // last records run with no idling on either side

	// One sensor record; reading[0] is temperature ... reading[5] is acidity
	typedef struct packed {
		word_t                   seq;
		word_t                   stamp;
		word_t [NumReadings-1:0] reading;
	} record_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_stall;
	word_t seq_number;
	word_t time_ms_low;
	word_t temp_reading;
	word_t depth_reading;
	word_t salinity_reading;
	word_t oxygen_reading;
	word_t chlorophyll_reading;
	word_t acidity_reading;
	logic  out_valid;
	logic  out_stall;
	word_t seq_echo;
	word_t packet_check;
	word_t time_change;
	word_t temp_change;
	word_t depth_change;
	word_t salinity_change;
	word_t oxygen_change;
	word_t chlorophyll_change;
	word_t acidity_change;
	int    fail_count;
	int    pending_count;

	bit      calm;       // set for the tail of the run: no input gaps, no output stalls
	record_t last_sent;  // previous record, seeds the drifting random records

	delta_packet_crc_encoder_core u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.seq_number         (seq_number),
		.time_ms_low        (time_ms_low),
		.temp_reading       (temp_reading),
		.depth_reading      (depth_reading),
		.salinity_reading   (salinity_reading),
		.oxygen_reading     (oxygen_reading),
		.chlorophyll_reading(chlorophyll_reading),
		.acidity_reading    (acidity_reading),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.seq_echo           (seq_echo),
		.packet_check       (packet_check),
		.time_change        (time_change),
		.temp_change        (temp_change),
		.depth_change       (depth_change),
		.salinity_change    (salinity_change),
		.oxygen_change      (oxygen_change),
		.chlorophyll_change (chlorophyll_change),
		.acidity_change     (acidity_change)
	);

	// Checker sits beside the block, watching both channels
	delta_packet_crc_encoder_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.seq_number         (seq_number),
		.time_ms_low        (time_ms_low),
		.temp_reading       (temp_reading),
		.depth_reading      (depth_reading),
		.salinity_reading   (salinity_reading),
		.oxygen_reading     (oxygen_reading),
		.chlorophyll_reading(chlorophyll_reading),
		.acidity_reading    (acidity_reading),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.seq_echo           (seq_echo),
		.packet_check       (packet_check),
		.time_change        (time_change),
		.temp_change        (temp_change),
		.depth_change       (depth_change),
		.salinity_change    (salinity_change),
		.oxygen_change      (oxygen_change),
		.chlorophyll_change (chlorophyll_change),
		.acidity_change     (acidity_change),
		.fail_count         (fail_count),
		.pending_count      (pending_count)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop: worst case is roughly 1300 words, each behind the longest input gap and
	// the longest output stall; 5 ms is over five times that.
	initial begin
		#5_000_000;
		$display("delta_packet_crc_encoder_core verification failed");
		$finish;
	end

	// Output-side back-pressure: random stall bursts, none once calm
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Called right after a rising edge. Optionally idles for a burst, then presents
	// the record and holds it until the block takes it. Returns at the accepting edge,
	// with in_valid still high so the next call can chain without a bubble.
	task automatic send_record(input record_t r);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid            <= 1'b1;
		seq_number          <= r.seq;
		time_ms_low         <= r.stamp;
		temp_reading        <= r.reading[0];
		depth_reading       <= r.reading[1];
		salinity_reading    <= r.reading[2];
		oxygen_reading      <= r.reading[3];
		chlorophyll_reading <= r.reading[4];
		acidity_reading     <= r.reading[5];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		last_sent = r;
	endtask

	// Record with every reading set to one value
	function automatic record_t flat(word_t seq, word_t stamp, word_t val);
		record_t r;
		r.seq   = seq;
		r.stamp = stamp;
		for (int i = 0; i < NumReadings; i++)
			r.reading[i] = val;
		return r;
	endfunction

	function automatic word_t pick_extreme();
		case ($urandom_range(0, 3))
			0: return 16'h0000;
			1: return 16'h7FFF;
			2: return 16'h8000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// Random record. Mostly slow drift from the last record (what real sensors do),
	// plus fully random words, rail values that force wrapped deltas, and repeats.
	function automatic record_t next_record(record_t prev);
		record_t r;
		int      mode;
		mode = $urandom_range(0, 9);
		r    = prev;
		if (mode <= 4) begin
			r.seq   = prev.seq + 16'd1;
			r.stamp = prev.stamp + word_t'($urandom_range(1, 1000));
			for (int i = 0; i < NumReadings; i++)
				r.reading[i] = prev.reading[i] + word_t'($urandom_range(0, 127)) - 16'd64;
		end else if (mode <= 7) begin
			r.seq   = word_t'($urandom);
			r.stamp = word_t'($urandom);
			for (int i = 0; i < NumReadings; i++)
				r.reading[i] = word_t'($urandom);
		end else if (mode == 8) begin
			r.seq   = pick_extreme();
			r.stamp = pick_extreme();
			for (int i = 0; i < NumReadings; i++)
				r.reading[i] = pick_extreme();
		end else begin
			// same values again: all deltas zero, only the sequence moves
			r.seq = prev.seq + 16'd1;
		end
		return r;
	endfunction

	initial begin
		record_t r;
		calm                <= 1'b0;
		arst_n              <= 1'b0;
		in_valid            <= 1'b0;
		seq_number          <= '0;
		time_ms_low         <= '0;
		temp_reading        <= '0;
		depth_reading       <= '0;
		salinity_reading    <= '0;
		oxygen_reading      <= '0;
		chlorophyll_reading <= '0;
		acidity_reading     <= '0;
		last_sent           = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// First record after reset: history is zero, so deltas echo the raw values.
		r.seq        = 16'h0001;
		r.stamp      = 16'h1234;
		r.reading[0] = 16'h0064;   // +100
		r.reading[1] = 16'hFF9C;   // -100
		r.reading[2] = 16'h7FFF;
		r.reading[3] = 16'h8000;
		r.reading[4] = 16'hFFFF;
		r.reading[5] = 16'h0001;
		send_record(r);
		// identical values: every delta zero
		r.seq = 16'h0002;
		send_record(r);
		send_record(flat(16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_record(flat(16'h0000, 16'h0000, 16'h0000));   // wraps up to +1
		send_record(flat(16'h8000, 16'h8000, 16'h8000));   // delta is the most negative
		send_record(flat(16'h8001, 16'h7FFF, 16'h7FFF));   // +65535 wraps to -1
		send_record(flat(16'h7FFF, 16'h8000, 16'h8000));   // -65535 wraps to +1
		send_record(flat(16'hAAAA, 16'h5555, 16'h5555));
		send_record(flat(16'h5555, 16'hAAAA, 16'hAAAA));
		send_record(flat(16'h0000, 16'h2AAA, 16'hD555));
		// alternating rails across the readings, then swapped
		r.seq   = 16'h00FF;
		r.stamp = 16'hFF00;
		for (int i = 0; i < NumReadings; i++)
			r.reading[i] = (i % 2 == 0) ? 16'h7FFF : 16'h8000;
		send_record(r);
		r.seq   = 16'hFF00;
		r.stamp = 16'h00FF;
		for (int i = 0; i < NumReadings; i++)
			r.reading[i] = (i % 2 == 0) ? 16'h8000 : 16'h7FFF;
		send_record(r);
		send_record(flat(16'hFFFF, 16'h0000, 16'h0000));
		send_record(flat(16'h1234, 16'h1234, 16'h1234));

		// --- random part ---
		for (int n = 0; n < RandomRecords; n++) begin
			if (n == RandomRecords - CalmTail)
				calm <= 1'b1;
			send_record(next_record(last_sent));
		end
		in_valid <= 1'b0;

		// drain: every predicted word must come out, then a margin for stray words
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0) begin
			$display("delta_packet_crc_encoder_core verification clean");
		end else begin
			$display("delta_packet_crc_encoder_core verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
src/dpce_pkg.sv
src/dpce_front.sv
src/dpce_queue.sv
src/dpce_back.sv
src/delta_packet_crc_encoder_core.sv
bench/delta_packet_crc_encoder_checker.sv
bench/delta_packet_crc_encoder_core_test.sv
